>>> rtl/balloc_pkg.sv
// Shared types, constants and helper functions for the buddy allocator.
package balloc_pkg;

    localparam int HEAP_BYTES   = 1024;
    localparam int MIN_BLOCK    = 8;
    localparam int HEADER_BYTES = 24;

    localparam int NGRAN     = HEAP_BYTES / MIN_BLOCK;
    localparam int GW        = $clog2(NGRAN);
    localparam int MAX_ORDER = GW;
    localparam int OW        = $clog2(MAX_ORDER + 1);
    localparam int MIN_SHIFT = $clog2(MIN_BLOCK);

    localparam int OFF_W  = 10;
    localparam int BYTE_W = 11;
    localparam int NEED_W = BYTE_W + 1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] alloc_bytes;
        logic [OFF_W-1:0]  free_offset;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [OFF_W-1:0]  block_offset;
        logic [BYTE_W-1:0] block_bytes;
        logic [BYTE_W-1:0] free_bytes;
    } t_resp;

    // One granule table entry.
    typedef struct packed {
        logic          start;
        logic          free;
        logic [OW-1:0] order;
    } t_entry;

    typedef struct packed {
        logic          we;
        logic [GW-1:0] waddr;
        t_entry        wdata;
        logic [GW-1:0] raddr;
    } t_mem_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_SPLIT,
        S_FCHECK,
        S_MERGE,
        S_FINAL,
        S_RESULT
    } t_state;

    // Smallest order whose block holds need bytes; top bit set when none does.
    function automatic logic [OW:0] fit_order(input logic [NEED_W-1:0] need);
        logic              found;
        logic [OW-1:0]     ord;
        logic [NEED_W-1:0] sz;
        found = 1'b0;
        ord   = '0;
        for (int k = 0; k <= MAX_ORDER; k++) begin
            sz = NEED_W'(MIN_BLOCK) << k;
            if (!found && sz >= need) begin
                found = 1'b1;
                ord   = OW'(k);
            end
        end
        return {~found, ord};
    endfunction

    function automatic logic [BYTE_W-1:0] block_size(input logic [OW-1:0] order);
        return BYTE_W'(MIN_BLOCK) << order;
    endfunction

endpackage

>>> rtl/balloc_mem.sv
// Granule table memory: one write port, one registered read port.
module balloc_mem (
    input  logic                  i_clk,
    input  balloc_pkg::t_mem_cmd  i_cmd,
    output balloc_pkg::t_entry    o_rdata
);

    balloc_pkg::t_entry mem [balloc_pkg::NGRAN];
    balloc_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        r_rdata <= mem[i_cmd.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/balloc_fsm.sv
// Request sequencer: table clear, first-fit search, split, free check and buddy merge.
module balloc_fsm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  balloc_pkg::t_req      i_in,
    output logic                  o_in_stall,
    input  logic                  i_slot_free,
    output logic                  o_res_load,
    output balloc_pkg::t_resp     o_res,
    output balloc_pkg::t_mem_cmd  o_mem_cmd,
    input  balloc_pkg::t_entry    i_mem_rdata
);

    localparam int GW     = balloc_pkg::GW;
    localparam int OW     = balloc_pkg::OW;
    localparam int BYTE_W = balloc_pkg::BYTE_W;
    localparam int OFF_W  = balloc_pkg::OFF_W;
    localparam int NEED_W = balloc_pkg::NEED_W;

    balloc_pkg::t_state r_state, n_state;
    logic [GW-1:0]      r_clr, n_clr;
    logic [GW:0]        r_g, n_g;
    logic [OW-1:0]      r_k, n_k;
    logic [OW-1:0]      r_ord, n_ord;
    logic [BYTE_W-1:0]  r_free_total, n_free_total;
    balloc_pkg::t_resp  r_res, n_res;

    logic              accept;
    logic [OW:0]       fit;
    logic              fit_fail;
    logic [OW-1:0]     fit_ord;
    logic              free_bad;
    logic [GW:0]       step_g;
    logic              srch_hit;
    logic              srch_end;
    logic              bud_ok;
    logic [GW-1:0]     ord_bit;
    logic [GW-1:0]     g_lo;
    logic [GW-1:0]     g_hi;
    logic [OW-1:0]     ord_up;
    logic [OW-1:0]     ord_dn;
    logic              merge_more;
    logic              split_more;
    logic              fc_ok;
    logic              fc_top;
    logic [OFF_W-1:0]  g_offset;
    balloc_pkg::t_entry top_entry;

    assign accept   = (r_state == balloc_pkg::S_IDLE) && i_in_valid;
    assign fit      = balloc_pkg::fit_order(NEED_W'(i_in.alloc_bytes)
                                            + NEED_W'(balloc_pkg::HEADER_BYTES));
    assign fit_fail = fit[OW];
    assign fit_ord  = fit[OW-1:0];
    assign free_bad = (i_in.free_offset[balloc_pkg::MIN_SHIFT-1:0] != '0) ||
                      ({1'b0, i_in.free_offset} >= (OFF_W+1)'(balloc_pkg::HEAP_BYTES));

    // Block walk: the entry just read is always a block start.
    assign step_g   = r_g + ((GW+1)'(1) << i_mem_rdata.order);
    assign srch_hit = i_mem_rdata.start && i_mem_rdata.free && (i_mem_rdata.order >= r_k);
    assign srch_end = step_g[GW];

    assign bud_ok     = i_mem_rdata.start && i_mem_rdata.free && (i_mem_rdata.order == r_ord);
    assign ord_bit    = GW'(1) << r_ord;
    assign g_lo       = r_g[GW-1:0] & ~ord_bit;
    assign g_hi       = r_g[GW-1:0] | ord_bit;
    assign ord_up     = r_ord + OW'(1);
    assign ord_dn     = r_ord - OW'(1);
    assign merge_more = (ord_up != OW'(balloc_pkg::MAX_ORDER));
    assign split_more = (r_ord > r_k);
    assign fc_ok      = i_mem_rdata.start && !i_mem_rdata.free;
    assign fc_top     = (i_mem_rdata.order == OW'(balloc_pkg::MAX_ORDER));
    assign g_offset   = OFF_W'(r_g[GW-1:0]) << balloc_pkg::MIN_SHIFT;

    assign top_entry = '{start: 1'b1, free: 1'b1, order: OW'(balloc_pkg::MAX_ORDER)};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            balloc_pkg::S_CLEAR: begin
                if (r_clr == GW'(balloc_pkg::NGRAN - 1)) n_state = balloc_pkg::S_IDLE;
            end
            balloc_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_in.req_type == balloc_pkg::REQ_FREE) begin
                        n_state = free_bad ? balloc_pkg::S_RESULT : balloc_pkg::S_FCHECK;
                    end else begin
                        n_state = fit_fail ? balloc_pkg::S_RESULT : balloc_pkg::S_SEARCH;
                    end
                end
            end
            balloc_pkg::S_SEARCH: begin
                if (srch_hit) n_state = balloc_pkg::S_SPLIT;
                else if (srch_end) n_state = balloc_pkg::S_RESULT;
            end
            balloc_pkg::S_SPLIT: begin
                if (!split_more) n_state = balloc_pkg::S_RESULT;
            end
            balloc_pkg::S_FCHECK: begin
                if (!fc_ok || fc_top) n_state = balloc_pkg::S_RESULT;
                else n_state = balloc_pkg::S_MERGE;
            end
            balloc_pkg::S_MERGE: begin
                if (!bud_ok) n_state = balloc_pkg::S_RESULT;
                else if (!merge_more) n_state = balloc_pkg::S_FINAL;
            end
            balloc_pkg::S_FINAL: begin
                n_state = balloc_pkg::S_RESULT;
            end
            balloc_pkg::S_RESULT: begin
                if (i_slot_free) n_state = balloc_pkg::S_IDLE;
            end
            default: n_state = balloc_pkg::S_CLEAR;
        endcase
    end

    // Datapath and table accesses
    always_comb begin
        n_clr        = r_clr;
        n_g          = r_g;
        n_k          = r_k;
        n_ord        = r_ord;
        n_free_total = r_free_total;
        n_res        = r_res;
        o_mem_cmd    = '0;
        unique case (r_state)
            balloc_pkg::S_CLEAR: begin
                o_mem_cmd.we    = 1'b1;
                o_mem_cmd.waddr = r_clr;
                o_mem_cmd.wdata = (r_clr == '0) ? top_entry : '0;
                n_clr           = r_clr + GW'(1);
            end
            balloc_pkg::S_IDLE: begin
                if (accept) begin
                    n_res = '{status: balloc_pkg::ST_OK, block_offset: '0,
                              block_bytes: '0, free_bytes: '0};
                    if (i_in.req_type == balloc_pkg::REQ_FREE) begin
                        n_g = {1'b0, i_in.free_offset[balloc_pkg::MIN_SHIFT +: GW]};
                        o_mem_cmd.raddr = i_in.free_offset[balloc_pkg::MIN_SHIFT +: GW];
                        if (free_bad) n_res.status = balloc_pkg::ST_BADFREE;
                    end else begin
                        n_k = fit_ord;
                        n_g = '0;
                        if (fit_fail) n_res.status = balloc_pkg::ST_NOMEM;
                    end
                end
            end
            balloc_pkg::S_SEARCH: begin
                if (srch_hit) begin
                    n_ord = i_mem_rdata.order;
                end else if (srch_end) begin
                    n_res.status = balloc_pkg::ST_NOMEM;
                end else begin
                    n_g             = step_g;
                    o_mem_cmd.raddr = step_g[GW-1:0];
                end
            end
            balloc_pkg::S_SPLIT: begin
                o_mem_cmd.we = 1'b1;
                if (split_more) begin
                    // upper half becomes a free block of one order less
                    o_mem_cmd.waddr = r_g[GW-1:0] + (GW'(1) << ord_dn);
                    o_mem_cmd.wdata = '{start: 1'b1, free: 1'b1, order: ord_dn};
                    n_ord           = ord_dn;
                end else begin
                    o_mem_cmd.waddr   = r_g[GW-1:0];
                    o_mem_cmd.wdata   = '{start: 1'b1, free: 1'b0, order: r_k};
                    n_free_total      = r_free_total - balloc_pkg::block_size(r_k);
                    n_res.block_offset = g_offset;
                    n_res.block_bytes  = balloc_pkg::block_size(r_k);
                end
            end
            balloc_pkg::S_FCHECK: begin
                if (!fc_ok) begin
                    n_res.status = balloc_pkg::ST_BADFREE;
                end else begin
                    n_ord              = i_mem_rdata.order;
                    n_free_total       = r_free_total + balloc_pkg::block_size(i_mem_rdata.order);
                    n_res.block_offset = g_offset;
                    n_res.block_bytes  = balloc_pkg::block_size(i_mem_rdata.order);
                    if (fc_top) begin
                        o_mem_cmd.we    = 1'b1;
                        o_mem_cmd.waddr = r_g[GW-1:0];
                        o_mem_cmd.wdata = '{start: 1'b1, free: 1'b1, order: i_mem_rdata.order};
                    end else begin
                        o_mem_cmd.raddr = r_g[GW-1:0] ^ (GW'(1) << i_mem_rdata.order);
                    end
                end
            end
            balloc_pkg::S_MERGE: begin
                o_mem_cmd.we = 1'b1;
                if (bud_ok) begin
                    // upper buddy disappears; lower one is written at the end
                    o_mem_cmd.waddr = g_hi;
                    o_mem_cmd.wdata = '0;
                    n_g             = {1'b0, g_lo};
                    n_ord           = ord_up;
                    o_mem_cmd.raddr = g_lo ^ (GW'(1) << ord_up);
                end else begin
                    o_mem_cmd.waddr = r_g[GW-1:0];
                    o_mem_cmd.wdata = '{start: 1'b1, free: 1'b1, order: r_ord};
                end
            end
            balloc_pkg::S_FINAL: begin
                o_mem_cmd.we    = 1'b1;
                o_mem_cmd.waddr = r_g[GW-1:0];
                o_mem_cmd.wdata = '{start: 1'b1, free: 1'b1, order: r_ord};
            end
            balloc_pkg::S_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= balloc_pkg::S_CLEAR;
            r_clr        <= '0;
            r_free_total <= BYTE_W'(balloc_pkg::HEAP_BYTES);
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_free_total <= n_free_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g   <= n_g;
        r_k   <= n_k;
        r_ord <= n_ord;
        r_res <= n_res;
    end

    assign o_in_stall  = (r_state != balloc_pkg::S_IDLE);
    assign o_res_load  = (r_state == balloc_pkg::S_RESULT) && i_slot_free;

    always_comb begin
        o_res            = r_res;
        o_res.free_bytes = r_free_total;
    end

endmodule

>>> rtl/buddy_allocator.sv
// Buddy allocator top level: sequencer, granule table and result register.
//
// Request channel (i_in_valid / o_in_stall / i_in): req_type selects allocate or
// free. Allocate adds the header to alloc_bytes, rounds up to a power-of-two
// block and takes the first free block in address order, splitting it down.
// Free releases the block at free_offset and merges it with free buddies.
// Result channel (o_out_valid / i_out_stall / o_out): one result per request,
// carrying status, block offset, block size and the free byte total.
// Allocate walks B blocks in the first-fit search (up to 32, one table read each)
// and then makes S halvings (up to 5); a failed search makes no halvings and a
// rejected size skips the search. Free checks the block and then makes M buddy
// merges (up to 5, one table read each); freeing the whole heap or a non-block
// offset makes no merges, and a misaligned offset skips the check.
// One request is in flight at a time; the next is accepted in the cycle after
// the result enters the output register, while that result may still wait.
// Reset runs a pass over all 128 granule table entries; o_in_stall stays high
// meanwhile. If the receiver stalls, the result holds in the output register
// and a finished request waits for the register to drain.
module buddy_allocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  balloc_pkg::t_req  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output balloc_pkg::t_resp o_out
);

    balloc_pkg::t_mem_cmd mem_cmd;
    balloc_pkg::t_entry   mem_rdata;
    balloc_pkg::t_resp    res;
    logic                 res_load;
    logic                 slot_free;
    logic                 r_out_valid;
    balloc_pkg::t_resp    r_out;

    assign slot_free = !r_out_valid || !i_out_stall;

    balloc_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .i_slot_free (slot_free),
        .o_res_load  (res_load),
        .o_res       (res),
        .o_mem_cmd   (mem_cmd),
        .i_mem_rdata (mem_rdata)
    );

    balloc_mem u_mem (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
